[hdl/gsdd_pkg.sv]
// ----------------------------------------------------------------------------
// gsdd_pkg
// Shared types, constants and tables for the gradient steering drive block.
// ----------------------------------------------------------------------------
package gsdd_pkg;

    localparam int FRAC_BITS    = 12;
    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_LEN     = 24;

    // Configuration register indexes.
    localparam logic [1:0] REG_STEER_GAIN     = 2'd0;
    localparam logic [1:0] REG_FORWARD_THRUST = 2'd1;
    localparam logic [1:0] REG_SIGNAL_FLOOR   = 2'd2;

    // Item modes.
    localparam logic MODE_STORE = 1'b0;
    localparam logic MODE_TICK  = 1'b1;

    typedef struct packed {
        logic               mode;
        logic signed [15:0] gradient_lateral;
        logic signed [15:0] gradient_forward;
        logic [31:0]        tick_tag;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] drive_left;
        logic signed [15:0] drive_right;
        logic               steering_active;
        logic [31:0]        tick_echo;
    } out_item_t;

    // A tick job handed from the front end to the execution unit.
    typedef struct packed {
        logic signed [15:0] lat;
        logic signed [15:0] fwd;
        logic signed [15:0] gain;
        logic signed [15:0] thrust;
        logic               active;
        logic [31:0]        tag;
    } job_t;

    // Arctangent step table in units of 2^-30 half turns.
    function automatic logic [28:0] atan_step(input logic [4:0] i);
        logic [28:0] v;
        begin
            case (i)
                5'd0:  v = 29'd268435456;
                5'd1:  v = 29'd158466702;
                5'd2:  v = 29'd83729454;
                5'd3:  v = 29'd42502378;
                5'd4:  v = 29'd21333666;
                5'd5:  v = 29'd10677233;
                5'd6:  v = 29'd5339919;
                5'd7:  v = 29'd2670123;
                5'd8:  v = 29'd1335082;
                5'd9:  v = 29'd667543;
                5'd10: v = 29'd333772;
                5'd11: v = 29'd166886;
                5'd12: v = 29'd83443;
                5'd13: v = 29'd41722;
                5'd14: v = 29'd20861;
                5'd15: v = 29'd10430;
                5'd16: v = 29'd5215;
                5'd17: v = 29'd2608;
                5'd18: v = 29'd1304;
                5'd19: v = 29'd652;
                5'd20: v = 29'd326;
                5'd21: v = 29'd163;
                5'd22: v = 29'd81;
                5'd23: v = 29'd41;
                default: v = 29'd0;
            endcase
            return v;
        end
    endfunction

endpackage

[hdl/gradient_steer_differential_drive.sv]
// Flow: a steering tick passes the gate, hand-off, squares, root, fold, CORDIC, divide
// and drive steps in that order; a plain tick skips root, fold, CORDIC, divide and ease.
// The execution unit takes a new tick only after the last result is popped; stores are
// taken every cycle while the front end is free.
// Reset: asynchronous, active low; registers return to gain 0.8, thrust 1.0,
// floor 0.06 and the stored vector to zero.
// ----------------------------------------------------------------------------
// gradient_steer_differential_drive
// Top level: front end, job queue, execution unit and one-entry result queue.
// ----------------------------------------------------------------------------
module gradient_steer_differential_drive
    import gsdd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  in_item_t    in_item,
    output logic        empty,
    input  logic        pop,
    output out_item_t   out_item,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic fj_valid;
    logic fj_ready;
    job_t fj;
    logic qj_valid;
    logic qj_ready;
    job_t qj;
    logic in_ready;
    logic res_valid;

    assign full      = !in_ready;
    assign empty     = !res_valid;
    assign cfg_ready = 1'b1;

    gsdd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (push),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .job_valid (fj_valid),
        .job_ready (fj_ready),
        .job       (fj)
    );

    gsdd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fj_valid),
        .wr_ready (fj_ready),
        .wr_data  (fj),
        .rd_valid (qj_valid),
        .rd_ready (qj_ready),
        .rd_data  (qj)
    );

    gsdd_exec u_exec (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (qj_valid),
        .job_ready (qj_ready),
        .job       (qj),
        .res_valid (res_valid),
        .res_ready (pop),
        .res       (out_item)
    );

endmodule

[hdl/gsdd_front.sv]
// ----------------------------------------------------------------------------
// gsdd_front
// Holds the configuration and stored vector, classifies items and issues
// tick jobs with the gate decision already made.
// ----------------------------------------------------------------------------
module gsdd_front
    import gsdd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_item,
    input  logic        cfg_valid,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output logic        job_valid,
    input  logic        job_ready,
    output job_t        job
);

    logic signed [15:0] gain_reg;
    logic signed [15:0] thrust_reg;
    logic [14:0]        floor_reg;
    logic signed [15:0] lat_reg;
    logic signed [15:0] fwd_reg;

    // Gate pipeline: one registered item waits here while the squares settle.
    typedef enum logic [1:0] { F_IDLE, F_SQ, F_CMP } fstate_t;
    fstate_t state_reg;
    logic [31:0] tag_reg;
    logic [31:0] sq_lat_reg;
    logic [31:0] sq_fwd_reg;
    logic [29:0] sq_floor_reg;

    logic [32:0] sq_sum;
    logic        gate;

    assign in_ready  = (state_reg == F_IDLE);
    assign sq_sum    = {1'b0, sq_lat_reg} + {1'b0, sq_fwd_reg};
    assign gate      = (sq_sum > {3'b000, sq_floor_reg}) && (gain_reg != 16'sd0);
    assign job_valid = (state_reg == F_CMP);
    assign job.lat    = lat_reg;
    assign job.fwd    = fwd_reg;
    assign job.gain   = gain_reg;
    assign job.thrust = thrust_reg;
    assign job.active = gate;
    assign job.tag    = tag_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg   <= 16'sd3277;
            thrust_reg <= 16'sd4096;
            floor_reg  <= 15'd246;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_STEER_GAIN:     gain_reg   <= cfg_data;
                REG_FORWARD_THRUST: thrust_reg <= cfg_data;
                REG_SIGNAL_FLOOR:   floor_reg  <= cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // Item classification and gate computation.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            lat_reg   <= '0;
            fwd_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                F_IDLE:
                begin
                    if (in_valid)
                    begin
                        if (in_item.mode == MODE_STORE)
                        begin
                            lat_reg <= in_item.gradient_lateral;
                            fwd_reg <= in_item.gradient_forward;
                        end
                        else
                        begin
                            tag_reg   <= in_item.tick_tag;
                            state_reg <= F_SQ;
                        end
                    end
                end
                F_SQ:
                begin
                    sq_lat_reg   <= 32'(lat_reg * lat_reg);
                    sq_fwd_reg   <= 32'(fwd_reg * fwd_reg);
                    sq_floor_reg <= floor_reg * floor_reg;
                    state_reg    <= F_CMP;
                end
                F_CMP:
                begin
                    if (job_ready)
                    begin
                        state_reg <= F_IDLE;
                    end
                end
                default: state_reg <= F_IDLE;
            endcase
        end
    end

    a_sq_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == F_CMP) |-> !sq_lat_reg[31])
        else $error("lateral square negative");
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !job_valid)
        else $error("front accepts while a job is pending");
    a_sq_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == F_SQ) |=> (state_reg == F_CMP))
        else $error("square stage skipped");

endmodule

[hdl/gsdd_queue.sv]
// ----------------------------------------------------------------------------
// gsdd_queue
// Two-entry job queue between the front end and the execution unit.
// ----------------------------------------------------------------------------
module gsdd_queue
    import gsdd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_valid,
    output logic wr_ready,
    input  job_t wr_data,
    output logic rd_valid,
    input  logic rd_ready,
    output job_t rd_data
);

    job_t       mem_reg [2];
    logic       wp_reg;
    logic       rp_reg;
    logic [1:0] cnt_reg;
    logic       do_wr;
    logic       do_rd;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem_reg[rp_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    // Storage.
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wp_reg] <= wr_data;
        end
    end

    // Pointers and count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (do_wr)
            begin
                wp_reg <= ~wp_reg;
            end
            if (do_rd)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, do_wr} - {1'b0, do_rd};
        end
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("queue count overflow");
    a_ptr_eq: assert property (@(posedge clk) disable iff (!rst_n)
        ((cnt_reg == 2'd0) || (cnt_reg == 2'd2)) |-> (wp_reg == rp_reg))
        else $error("queue pointers inconsistent");
    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        (do_wr && !do_rd) |=> (cnt_reg == $past(cnt_reg) + 2'd1))
        else $error("queue count lost a write");

endmodule

[hdl/gsdd_exec.sv]
// ----------------------------------------------------------------------------
// gsdd_exec
// Execution unit: bit-serial square root, CORDIC vectoring, a restoring
// divider and the drive arithmetic, sequenced one step per cycle.
// ----------------------------------------------------------------------------
module gsdd_exec
    import gsdd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      job_valid,
    output logic      job_ready,
    input  job_t      job,
    output logic      res_valid,
    input  logic      res_ready,
    output out_item_t res
);

    typedef enum logic [3:0] {
        S_IDLE, S_SQ, S_SUM, S_ROOT, S_PRE, S_CORD, S_DIV, S_EASE,
        S_MUL, S_OUT, S_HOLD
    } state_t;

    localparam int CSTEPS = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
    localparam logic signed [63:0] LIM = 64'sd4 <<< FRAC_BITS;
    // The sum sits at scale 2^-(FRAC_BITS+30); four times it at Q FRAC_BITS
    // is a right shift by 28 whatever FRAC_BITS is.
    localparam int RSH = 28;

    state_t             state_reg;
    logic [5:0]         cnt_reg;
    job_t               job_reg;
    // Squares and root.
    logic [31:0]        sql_reg;
    logic [31:0]        sqf_reg;
    logic [62:0]        rem_reg;
    logic [62:0]        root_reg;
    // CORDIC.
    logic signed [35:0] x_reg;
    logic signed [35:0] y_reg;
    logic signed [32:0] ang_reg;
    // Divider on magnitudes: |3*fwd*2^43| / M.
    logic [62:0]        num_reg;
    logic [62:0]        quo_reg;
    logic [32:0]        drem_reg;
    logic               neg_reg;
    logic signed [31:0] ease_reg;
    logic signed [63:0] fraw_reg;
    logic signed [63:0] sraw_reg;

    logic signed [35:0] dx;
    logic signed [35:0] dy;
    logic [4:0]         cidx;
    logic [32:0]        dshift;
    logic signed [64:0] c_full;
    logic signed [63:0] sum_l;
    logic signed [63:0] sum_r;

    function automatic logic signed [15:0] to_drive(input logic signed [63:0] s);
        logic signed [63:0] d;
        begin
            d = (s + (64'sd1 <<< (RSH - 1))) >>> RSH;
            if (d > LIM)
            begin
                d = LIM;
            end
            if (d < -LIM)
            begin
                d = -LIM;
            end
            return d[15:0];
        end
    endfunction

    assign cidx   = cnt_reg[4:0];
    assign dx     = y_reg >>> cidx;
    assign dy     = x_reg >>> cidx;
    assign dshift = {drem_reg[31:0], num_reg[62]};
    assign c_full = (65'sd1 <<< 28) + (neg_reg ? -$signed({2'b00, quo_reg})
                                                : $signed({2'b00, quo_reg}));
    assign sum_l  = fraw_reg + sraw_reg;
    assign sum_r  = fraw_reg - sraw_reg;

    assign job_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_HOLD);

    // Sequencer: root by bit-serial digit recurrence, one bit per cycle.
    logic [62:0] rb;
    logic [62:0] rtry;
    assign rb   = 63'd1 << {cnt_reg[4:0], 1'b0};
    assign rtry = root_reg + rb;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (job_valid)
                    begin
                        job_reg   <= job;
                        state_reg <= S_SQ;
                    end
                end
                S_SQ:
                begin
                    sql_reg   <= 32'(job_reg.lat * job_reg.lat);
                    sqf_reg   <= 32'(job_reg.fwd * job_reg.fwd);
                    state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    // Radicand is (lat^2 + fwd^2) << 30, below 2^62.
                    rem_reg   <= {(33'(sql_reg) + 33'(sqf_reg)), 30'd0};
                    root_reg  <= '0;
                    cnt_reg   <= 6'd30;
                    state_reg <= job_reg.active ? S_ROOT : S_MUL;
                    ease_reg  <= 32'sd1 <<< 30;
                    sraw_reg  <= '0;
                end
                S_ROOT:
                begin
                    // Rooting with root register kept at scale of the bit.
                    if (rem_reg >= rtry)
                    begin
                        rem_reg  <= rem_reg - rtry;
                        root_reg <= (root_reg >> 1) + rb;
                    end
                    else
                    begin
                        root_reg <= root_reg >> 1;
                    end
                    if (cnt_reg == 6'd0)
                    begin
                        state_reg <= S_PRE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 6'd1;
                    end
                end
                S_PRE:
                begin
                    // Quadrant fold for CORDIC; operands prescaled by 2^16.
                    if (job_reg.fwd < 0)
                    begin
                        if (job_reg.lat >= 0)
                        begin
                            x_reg   <= 36'(job_reg.lat) <<< 16;
                            y_reg   <= -(36'(job_reg.fwd) <<< 16);
                            ang_reg <= 33'sd1 <<< 29;
                        end
                        else
                        begin
                            x_reg   <= -(36'(job_reg.lat) <<< 16);
                            y_reg   <= 36'(job_reg.fwd) <<< 16;
                            ang_reg <= -(33'sd1 <<< 29);
                        end
                    end
                    else
                    begin
                        x_reg   <= 36'(job_reg.fwd) <<< 16;
                        y_reg   <= 36'(job_reg.lat) <<< 16;
                        ang_reg <= '0;
                    end
                    cnt_reg   <= '0;
                    state_reg <= S_CORD;
                end
                S_CORD:
                begin
                    if (y_reg > 0)
                    begin
                        x_reg   <= x_reg + dx;
                        y_reg   <= y_reg - dy;
                        ang_reg <= ang_reg + $signed({4'd0, atan_step(cidx)});
                    end
                    else
                    begin
                        x_reg   <= x_reg - dx;
                        y_reg   <= y_reg + dy;
                        ang_reg <= ang_reg - $signed({4'd0, atan_step(cidx)});
                    end
                    if (cnt_reg == 6'(CSTEPS - 1))
                    begin
                        state_reg <= S_DIV;
                        neg_reg   <= job_reg.fwd[15];
                        num_reg   <= 63'(3 * (job_reg.fwd[15] ? -32'(job_reg.fwd)
                                                               : 32'(job_reg.fwd))) << 43;
                        drem_reg  <= '0;
                        quo_reg   <= '0;
                        cnt_reg   <= 6'd62;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 6'd1;
                    end
                end
                S_DIV:
                begin
                    // Restoring division, one quotient bit per cycle.
                    if (dshift >= {1'b0, root_reg[31:0]})
                    begin
                        drem_reg <= dshift - {1'b0, root_reg[31:0]};
                        quo_reg  <= {quo_reg[61:0], 1'b1};
                    end
                    else
                    begin
                        drem_reg <= dshift;
                        quo_reg  <= {quo_reg[61:0], 1'b0};
                    end
                    num_reg <= {num_reg[61:0], 1'b0};
                    if (cnt_reg == 6'd0)
                    begin
                        state_reg <= S_EASE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 6'd1;
                    end
                end
                S_EASE:
                begin
                    if (c_full < 0)
                    begin
                        ease_reg <= '0;
                    end
                    else if (c_full > (65'sd1 <<< 30))
                    begin
                        ease_reg <= 32'sd1 <<< 30;
                    end
                    else
                    begin
                        ease_reg <= c_full[31:0];
                    end
                    sraw_reg  <= 64'(job_reg.gain * ang_reg);
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    fraw_reg  <= 64'(job_reg.thrust * ease_reg);
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    res.drive_left      <= to_drive(sum_l);
                    res.drive_right     <= to_drive(sum_r);
                    res.steering_active <= job_reg.active;
                    res.tick_echo       <= job_reg.tag;
                    state_reg           <= S_HOLD;
                end
                S_HOLD:
                begin
                    if (res_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> res_valid)
        else $error("result dropped");
    a_ease_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL) |-> (ease_reg >= 0 && ease_reg <= (32'sd1 <<< 30)))
        else $error("ease out of range");
    a_inactive: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && !job_reg.active) |-> (sraw_reg == 0))
        else $error("steer without gate");

endmodule
